>>> rtl/fwvp_pkg.sv
// Shared types, constants and saturation helpers for the four-wheel velocity PID unit.
package fwvp_pkg;

  localparam int WHEEL_COUNT   = 4;
  localparam int WH_W          = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int GAIN_W    = 31;
  localparam int WEIGHT_W  = 17;
  localparam int CFG_IDX_W = 3;

  // shared multiplier: signed A (up to a 33-bit difference) times non-negative B
  localparam int OPA_W  = DIFF_W;
  localparam int OPB_W  = DATA_W;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 31'd327680;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST    = 31'd1310720;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST    = 31'd0;
  localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 17'd3277;
  localparam logic [GAIN_W-1:0]   INTEG_LIMIT_RST   = 31'd19661;
  localparam logic [WEIGHT_W-1:0] LOOP_PERIOD_RST   = 17'd655;
  localparam logic [GAIN_W-1:0]   LOOP_RATE_RST     = 31'd6553600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_INTEG_GAIN    = 3'd1,
    CFG_DERIV_GAIN    = 3'd2,
    CFG_SMOOTH_WEIGHT = 3'd3,
    CFG_INTEG_LIMIT   = 3'd4,
    CFG_LOOP_PERIOD   = 3'd5,
    CFG_LOOP_RATE     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [WEIGHT_W-1:0] smooth_weight;
    logic [GAIN_W-1:0]   integ_limit;
    logic [WEIGHT_W-1:0] loop_period;
    logic [GAIN_W-1:0]   loop_rate;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] angle_front_left;
    logic signed [DATA_W-1:0] angle_back_left;
    logic signed [DATA_W-1:0] angle_front_right;
    logic signed [DATA_W-1:0] angle_back_right;
    logic signed [DATA_W-1:0] target_front_left;
    logic signed [DATA_W-1:0] target_back_left;
    logic signed [DATA_W-1:0] target_front_right;
    logic signed [DATA_W-1:0] target_back_right;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive_front_left;
    logic signed [DATA_W-1:0] drive_back_left;
    logic signed [DATA_W-1:0] drive_front_right;
    logic signed [DATA_W-1:0] drive_back_right;
  } result_t;

  // microcode fields
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DELTA_RATE,
    MUL_OLD_1W,
    MUL_VEL_W,
    MUL_ERR_PERIOD,
    MUL_DERR_RATE,
    MUL_ERR_KP,
    MUL_INTEG_KI,
    MUL_DRATE_KD
  } mul_op_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_SET_SH,
    ACC_ADD_SH,
    ACC_SET_RAW,
    ACC_ADD_RAW,
    ACC_INTEG_SH
  } acc_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_VEL,
    WR_SMOOTH,
    WR_ERR,
    WR_INTEG,
    WR_DRATE,
    WR_DRIVE
  } wr_op_e;

  typedef enum logic [1:0] {
    SQ_NEXT,
    SQ_LOOP,
    SQ_END
  } seq_op_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  localparam int UPC_W = 4;

  typedef enum logic [UPC_W-1:0] {
    UC_DELTA,
    UC_OLD,
    UC_VEL,
    UC_VEL_W,
    UC_WAIT,
    UC_SMOOTH,
    UC_ERR,
    UC_ERR_PER,
    UC_DERR,
    UC_ERR_KP,
    UC_INTEG_KI,
    UC_DRATE_KD,
    UC_SUM_KI,
    UC_DRIVE,
    UC_END
  } uc_step_e;

  typedef struct packed {
    mul_op_e          mul;
    acc_op_e          acc;
    wr_op_e           wr;
    seq_op_e          seq;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t       word;
    logic [WH_W-1:0]  wheel;
    logic             load_item;
  } dp_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp_lim(input logic signed [ACC_W-1:0] v,
                                                         input logic [GAIN_W-1:0] lim);
    logic signed [ACC_W-1:0] pos;
    logic signed [ACC_W-1:0] neg;
    pos = {{(ACC_W-GAIN_W){1'b0}}, lim};
    neg = -pos;
    if (v > pos) begin
      return pos[DATA_W-1:0];
    end else if (v < neg) begin
      return neg[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/fwvp_ucode_rom.sv
// Control store: one microcode word per step of the per-wheel program.
module fwvp_ucode_rom import fwvp_pkg::*; (
  input  logic [UPC_W-1:0] addr,
  output ctrl_word_t       word
);

  // a multiply's operands are registered, then its product, before a later step reads it from the product register
  always_comb begin
    word = '{mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE, seq: SQ_NEXT, target: UC_DELTA};
    unique case (addr)
      UC_DELTA:    word.mul = MUL_DELTA_RATE;
      UC_OLD:      word.mul = MUL_OLD_1W;
      UC_VEL: begin
        word.acc = ACC_SET_SH;
        word.wr  = WR_VEL;
      end
      UC_VEL_W: begin
        word.mul = MUL_VEL_W;
        word.acc = ACC_SET_RAW;
      end
      UC_WAIT:     word.acc = ACC_HOLD;
      UC_SMOOTH: begin
        word.acc = ACC_ADD_RAW;
        word.wr  = WR_SMOOTH;
      end
      UC_ERR:      word.wr  = WR_ERR;
      UC_ERR_PER:  word.mul = MUL_ERR_PERIOD;
      UC_DERR:     word.mul = MUL_DERR_RATE;
      UC_ERR_KP: begin
        word.mul = MUL_ERR_KP;
        word.acc = ACC_INTEG_SH;
        word.wr  = WR_INTEG;
      end
      UC_INTEG_KI: begin
        word.mul = MUL_INTEG_KI;
        word.acc = ACC_SET_SH;
        word.wr  = WR_DRATE;
      end
      UC_DRATE_KD: begin
        word.mul = MUL_DRATE_KD;
        word.acc = ACC_SET_SH;
      end
      UC_SUM_KI:   word.acc = ACC_ADD_SH;
      UC_DRIVE: begin
        word.acc    = ACC_ADD_SH;
        word.wr     = WR_DRIVE;
        word.seq    = SQ_LOOP;
        word.target = UC_DELTA;
      end
      UC_END:      word.seq = SQ_END;
      default:     word.seq = SQ_END;
    endcase
  end

endmodule

>>> rtl/fwvp_sequencer.sv
// Step counter, wheel counter and jump logic that walk the microcode once per wheel, for every wheel, on each tick.
module fwvp_sequencer import fwvp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     out_free,
  output logic     busy,
  output logic     done,
  output dp_ctrl_t ctrl
);

  localparam logic [WH_W-1:0] LAST_WHEEL = WH_W'(WHEEL_COUNT - 1);

  seq_state_e       state;
  seq_state_e       state_next;
  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic [WH_W-1:0]  wheel;
  logic [WH_W-1:0]  wheel_next;
  ctrl_word_t       word;

  fwvp_ucode_rom u_rom (
    .addr (upc),
    .word (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      upc   <= UC_END;
      wheel <= '0;
    end else begin
      state <= state_next;
      upc   <= upc_next;
      wheel <= wheel_next;
    end
  end

  always_comb begin
    state_next = state;
    upc_next   = upc;
    wheel_next = wheel;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          upc_next   = UC_DELTA;
          wheel_next = '0;
        end
      end
      ST_RUN: begin
        unique case (word.seq)
          SQ_NEXT: upc_next = upc + UPC_W'(1);
          SQ_LOOP: begin
            if (wheel == LAST_WHEEL) begin
              upc_next = upc + UPC_W'(1);
            end else begin
              wheel_next = wheel + WH_W'(1);
              upc_next   = word.target;
            end
          end
          SQ_END: begin
            // hold here until the output register can take the result
            if (out_free) begin
              done       = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            state_next = ST_IDLE;
            upc_next   = UC_END;
          end
        endcase
      end
    endcase
  end

  assign busy = (state == ST_RUN);
  assign ctrl = '{word: word, wheel: wheel, load_item: start && (state == ST_IDLE)};

`ifndef SYNTHESIS
  a_idle_parked: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> upc == UC_END)
    else $error("sequencer idle away from the end step");
  a_start_entry: assert property (@(posedge clk) disable iff (rst)
    start && state == ST_IDLE |=> state == ST_RUN && upc == UC_DELTA && wheel == '0)
    else $error("program did not start at first step of first wheel");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    done |-> upc == UC_END && wheel == LAST_WHEEL)
    else $error("finished before all wheels were processed");
`endif

endmodule

>>> rtl/fwvp_datapath.sv
// Shared multiplier, accumulator, scratch registers and per-wheel state.
module fwvp_datapath import fwvp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_ctrl_t ctrl,
  input  cfg_t     cfg,
  input  item_t    item,
  output result_t  lanes
);

  localparam logic [OPB_W-1:0] ONE_FIX = OPB_W'(1) << FRAC_BITS;

  logic signed [DATA_W-1:0] in_angle    [WHEEL_COUNT];
  logic signed [DATA_W-1:0] in_target   [WHEEL_COUNT];
  logic signed [DATA_W-1:0] drive       [WHEEL_COUNT];
  logic signed [DATA_W-1:0] prev_angle  [WHEEL_COUNT];
  logic signed [DATA_W-1:0] smooth_vel  [WHEEL_COUNT];
  logic signed [DATA_W-1:0] integ_sum   [WHEEL_COUNT];
  logic signed [DATA_W-1:0] prev_err    [WHEEL_COUNT];

  logic signed [DATA_W-1:0] t_vel;
  logic signed [DATA_W-1:0] t_smooth;
  logic signed [DATA_W-1:0] t_err;
  logic signed [DATA_W-1:0] t_integ;
  logic signed [DATA_W-1:0] t_drate;

  logic [WH_W-1:0]          wh;
  logic [OPB_W-1:0]         w_ext;
  logic [OPB_W-1:0]         w_eff;
  logic signed [DATA_W-1:0] delta;
  logic signed [DIFF_W-1:0] derr;
  logic signed [OPA_W-1:0]  a_next;
  logic [OPB_W-1:0]         b_next;
  logic signed [OPA_W-1:0]  op_a;
  logic [OPB_W-1:0]         op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  sum_val;
  logic signed [ACC_W-1:0]  err_diff;

  assign wh    = ctrl.wheel;
  assign w_ext = OPB_W'(cfg.smooth_weight);
  assign w_eff = (w_ext > ONE_FIX) ? ONE_FIX : w_ext;
  assign delta = in_angle[wh] - prev_angle[wh];
  assign derr  = DIFF_W'(t_err) - DIFF_W'(prev_err[wh]);

  // operand select, registered in front of the multiplier
  always_comb begin
    a_next = '0;
    b_next = '0;
    unique case (ctrl.word.mul)
      MUL_DELTA_RATE: begin
        a_next = OPA_W'(delta);
        b_next = OPB_W'(cfg.loop_rate);
      end
      MUL_OLD_1W: begin
        a_next = OPA_W'(smooth_vel[wh]);
        b_next = ONE_FIX - w_eff;
      end
      MUL_VEL_W: begin
        a_next = OPA_W'(t_vel);
        b_next = w_eff;
      end
      MUL_ERR_PERIOD: begin
        a_next = OPA_W'(t_err);
        b_next = OPB_W'(cfg.loop_period);
      end
      MUL_DERR_RATE: begin
        a_next = derr;
        b_next = OPB_W'(cfg.loop_rate);
      end
      MUL_ERR_KP: begin
        a_next = OPA_W'(t_err);
        b_next = OPB_W'(cfg.prop_gain);
      end
      MUL_INTEG_KI: begin
        a_next = OPA_W'(t_integ);
        b_next = OPB_W'(cfg.integ_gain);
      end
      MUL_DRATE_KD: begin
        a_next = OPA_W'(t_drate);
        b_next = OPB_W'(cfg.deriv_gain);
      end
      default: ;
    endcase
  end

  // arithmetic shift of a signed product is floor division by 2^FRAC_BITS
  assign prod_sh = prod >>> FRAC_BITS;

  always_comb begin
    base   = acc;
    addend = '0;
    unique case (ctrl.word.acc)
      ACC_SET_SH: begin
        base   = '0;
        addend = ACC_W'(prod_sh);
      end
      ACC_ADD_SH:  addend = ACC_W'(prod_sh);
      ACC_SET_RAW: begin
        base   = '0;
        addend = ACC_W'(prod);
      end
      ACC_ADD_RAW: addend = ACC_W'(prod);
      ACC_INTEG_SH: begin
        base   = ACC_W'(integ_sum[wh]);
        addend = ACC_W'(prod_sh);
      end
      default: ;
    endcase
  end

  assign sum_val  = base + addend;
  assign err_diff = ACC_W'(in_target[wh]) - ACC_W'(t_smooth);

  always_ff @(posedge clk) begin
    op_a <= a_next;
    op_b <= b_next;
    prod <= PROD_W'(op_a * $signed(op_b));
    acc  <= sum_val;
    if (ctrl.load_item) begin
      in_angle[0]  <= item.angle_front_left;
      in_angle[1]  <= item.angle_back_left;
      in_angle[2]  <= item.angle_front_right;
      in_angle[3]  <= item.angle_back_right;
      in_target[0] <= item.target_front_left;
      in_target[1] <= item.target_back_left;
      in_target[2] <= item.target_front_right;
      in_target[3] <= item.target_back_right;
    end
    unique case (ctrl.word.wr)
      WR_VEL:    t_vel    <= sat32(sum_val);
      // the smoothing sum is floored once, after both terms are added
      WR_SMOOTH: t_smooth <= sat32(sum_val >>> FRAC_BITS);
      WR_ERR:    t_err    <= sat32(err_diff);
      WR_INTEG:  t_integ  <= clamp_lim(sum_val, cfg.integ_limit);
      WR_DRATE:  t_drate  <= sat32(sum_val);
      WR_DRIVE:  drive[wh] <= sat32(sum_val);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        prev_angle[i] <= '0;
        smooth_vel[i] <= '0;
        integ_sum[i]  <= '0;
        prev_err[i]   <= '0;
      end
    end else if (ctrl.word.wr == WR_DRIVE) begin
      prev_angle[wh] <= in_angle[wh];
      smooth_vel[wh] <= t_smooth;
      integ_sum[wh]  <= t_integ;
      prev_err[wh]   <= t_err;
    end
  end

  assign lanes.drive_front_left  = drive[0];
  assign lanes.drive_back_left   = drive[1];
  assign lanes.drive_front_right = drive[2];
  assign lanes.drive_back_right  = drive[3];

endmodule

>>> rtl/four_wheel_velocity_pid_unit.sv
// Four-wheel velocity PID unit: top level with configuration registers and output register.
//
// Usage: each control tick is one transfer on the item channel (item_valid/item_stall)
// carrying four wheel angles and four velocity targets, signed Q16.16. The unit answers
// with one transfer on the result channel (result_valid/result_stall) holding the four
// saturated drive values. Gains, smoothing weight, integral limit, tick period and rate
// are written over the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data); the user
// must write them only while idle, as the unit does not enforce this. cfg_ready is always
// high and unknown indexes are dropped. Schedule: one shared 33x32 multiplier runs a
// 14-step microprogram per wheel, for all four wheels and then one wrap-up step; the
// result enters the output register as that step ends, and from then on the next item can be taken.
// item_stall is high while the program runs. A finished result sits in the output
// register; while result_stall holds it there the unit still takes and works on the next
// item, and waits at its last step until the register is free.
// Reset (rst, synchronous, active high) restores the default configuration, clears all
// per-wheel history (previous angle, filtered velocity, integral, previous error) and
// empties the output register.
module four_wheel_velocity_pid_unit import fwvp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cfg_t     cfg;
  dp_ctrl_t ctrl;
  result_t  lanes;
  logic     busy;
  logic     done;
  logic     start;
  logic     out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = busy;
  assign start      = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{prop_gain:     PROP_GAIN_RST,
               integ_gain:    INTEG_GAIN_RST,
               deriv_gain:    DERIV_GAIN_RST,
               smooth_weight: SMOOTH_WEIGHT_RST,
               integ_limit:   INTEG_LIMIT_RST,
               loop_period:   LOOP_PERIOD_RST,
               loop_rate:     LOOP_RATE_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:    cfg.integ_gain    <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:    cfg.deriv_gain    <= cfg_data[GAIN_W-1:0];
        CFG_SMOOTH_WEIGHT: cfg.smooth_weight <= cfg_data[WEIGHT_W-1:0];
        CFG_INTEG_LIMIT:   cfg.integ_limit   <= cfg_data[GAIN_W-1:0];
        CFG_LOOP_PERIOD:   cfg.loop_period   <= cfg_data[WEIGHT_W-1:0];
        CFG_LOOP_RATE:     cfg.loop_rate     <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  fwvp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .busy     (busy),
    .done     (done),
    .ctrl     (ctrl)
  );

  fwvp_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .cfg   (cfg),
    .item  (item),
    .lanes (lanes)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result <= lanes;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item transfer did not start the program");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    done |=> result_valid && result == $past(lanes))
    else $error("finished result not loaded into output register");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !done |=> !result_valid)
    else $error("result repeated after transfer");
`endif

endmodule
